[design/usbce_pkg.sv]
// Shared types and constants for the USB control endpoint handler.
package usbce_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_EP0_PACKET_SIZE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_DESC_LENGTH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CONFIG_DESC_LENGTH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_STRING0_LENGTH     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_STRING1_LENGTH     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_STRING2_LENGTH     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_STRING3_LENGTH     = 3'd6;

  // Event opcodes.
  localparam logic [1:0] OP_BUS_RESET   = 2'd0;
  localparam logic [1:0] OP_TRANSACTION = 2'd1;
  localparam logic [1:0] OP_STALL_CLEAR = 2'd2;

  // Device phases.
  localparam logic [1:0] PHASE_POWERED    = 2'd0;
  localparam logic [1:0] PHASE_DEFAULT    = 2'd1;
  localparam logic [1:0] PHASE_ADDRESSED  = 2'd2;
  localparam logic [1:0] PHASE_CONFIGURED = 2'd3;

  // Data sources for IN chunks.
  localparam logic [2:0] SRC_DEVICE  = 3'd0;
  localparam logic [2:0] SRC_CONFIG  = 3'd1;
  localparam logic [2:0] SRC_STRING0 = 3'd2;
  localparam logic [2:0] SRC_CUR_CFG = 3'd6;
  localparam logic [2:0] SRC_ZERO    = 3'd7;

  // Standard request codes and descriptor types.
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_ASSIGN_ADDRESS    = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] DESC_DEVICE           = 8'd1;
  localparam logic [7:0] DESC_CONFIG           = 8'd2;
  localparam logic [7:0] DESC_STRING           = 8'd3;
  localparam logic [7:0] RT_TYPE_MASK          = 8'h60;
  localparam logic [7:0] RT_STD_DEVICE_IN      = 8'h80;

  localparam logic [6:0] MAX_PACKET = 7'd64;

  typedef enum logic [2:0] {
    ACT_IGNORE  = 3'd0,
    ACT_STALL   = 3'd1,
    ACT_SEND_IN = 3'd2,
    ACT_ZLP_IN  = 3'd3,
    ACT_REARM   = 3'd4,
    ACT_OUT_OK  = 3'd5,
    ACT_FORWARD = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    STAGE_SETUP = 2'd0,
    STAGE_IN    = 2'd1,
    STAGE_OUT   = 2'd2
  } stage_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  endpoint;
    logic        direction_in;
    logic        is_setup;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [7:0]  value_low;
    logic [7:0]  value_high;
    logic [15:0] request_length;
    logic [9:0]  out_byte_count;
  } item_t;

  typedef struct packed {
    logic [6:0]  ep0_packet_size;
    logic [7:0]  device_desc_length;
    logic [15:0] config_desc_length;
    logic [7:0]  string0_length;
    logic [7:0]  string1_length;
    logic [7:0]  string2_length;
    logic [7:0]  string3_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  device_phase;
    stage_t      transfer_stage;
    logic [6:0]  pending_address;
    logic [6:0]  applied_address;
    logic [7:0]  selected_config;
    logic [15:0] bytes_remaining;
    logic [2:0]  current_source;
    logic [15:0] current_offset;
    logic        in_toggle;
    logic        out_toggle;
    logic [15:0] out_total;
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [2:0]  data_source;
    logic [15:0] source_offset;
    logic [6:0]  chunk_length;
    logic        data_toggle;
    logic [1:0]  device_status;
    logic [6:0]  bus_address;
    logic [7:0]  active_configuration;
    logic        bulk_enabled;
  } result_t;

endpackage

[design/usb_control_endpoint_handler.sv]
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle unless out_stall holds a result; the decode between the two registers is single-pass.
// While the result register waits on out_stall, the input register takes a new item only if it holds none.
// Configuration writes are taken every cycle (cfg_ready is always high).
// Synchronous reset clears the device state and both valid flags and loads the packet-size and length defaults.
// No clearing pass is needed after reset; the block accepts items in the next cycle.
module usb_control_endpoint_handler (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Event channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [3:0]  endpoint,
  input  logic        direction_in,
  input  logic        is_setup,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [7:0]  value_low,
  input  logic [7:0]  value_high,
  input  logic [15:0] request_length,
  input  logic [9:0]  out_byte_count,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [2:0]  data_source,
  output logic [15:0] source_offset,
  output logic [6:0]  chunk_length,
  output logic        data_toggle,
  output logic [1:0]  device_status,
  output logic [6:0]  bus_address,
  output logic [7:0]  active_configuration,
  output logic        bulk_enabled
);

  usbce_pkg::cfg_t    cfg;
  usbce_pkg::state_t  state;
  usbce_pkg::state_t  state_next;
  usbce_pkg::item_t   s1_item;
  logic               s1_valid;
  usbce_pkg::result_t step_res;
  usbce_pkg::result_t result;
  logic               out_load;
  logic               in_take;

  assign cfg_ready = 1'b1;
  assign out_load  = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !out_load;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ep0_packet_size    <= 7'd64;
      cfg.device_desc_length <= 8'd18;
      cfg.config_desc_length <= 16'd32;
      cfg.string0_length     <= 8'd4;
      cfg.string1_length     <= 8'd20;
      cfg.string2_length     <= 8'd18;
      cfg.string3_length     <= 8'd18;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        usbce_pkg::CFG_EP0_PACKET_SIZE:    cfg.ep0_packet_size    <= cfg_data[6:0];
        usbce_pkg::CFG_DEVICE_DESC_LENGTH: cfg.device_desc_length <= cfg_data[7:0];
        usbce_pkg::CFG_CONFIG_DESC_LENGTH: cfg.config_desc_length <= cfg_data;
        usbce_pkg::CFG_STRING0_LENGTH:     cfg.string0_length     <= cfg_data[7:0];
        usbce_pkg::CFG_STRING1_LENGTH:     cfg.string1_length     <= cfg_data[7:0];
        usbce_pkg::CFG_STRING2_LENGTH:     cfg.string2_length     <= cfg_data[7:0];
        usbce_pkg::CFG_STRING3_LENGTH:     cfg.string3_length     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= '{opcode, endpoint, direction_in, is_setup, request_type, request_code,
                   value_low, value_high, request_length, out_byte_count};
    end
  end

  usbce_step u_step (
    .item (s1_item),
    .cur  (state),
    .cfg  (cfg),
    .nxt  (state_next),
    .res  (step_res)
  );

  // The device state advances exactly when an item moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_valid && out_load) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_load) begin
      result <= step_res;
    end
  end

  assign action               = result.action;
  assign data_source          = result.data_source;
  assign source_offset        = result.source_offset;
  assign chunk_length         = result.chunk_length;
  assign data_toggle          = result.data_toggle;
  assign device_status        = result.device_status;
  assign bus_address          = result.bus_address;
  assign active_configuration = result.active_configuration;
  assign bulk_enabled         = result.bulk_enabled;

  a_chunk_only_on_send: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != usbce_pkg::ACT_SEND_IN |->
      data_source == 3'd0 && source_offset == 16'd0 && chunk_length == 7'd0)
    else $error("chunk fields set on a result that sends no IN data");

  a_chunk_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> chunk_length <= usbce_pkg::MAX_PACKET)
    else $error("chunk longer than one full-speed packet");

  a_bulk_tracks_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bulk_enabled == (device_status == usbce_pkg::PHASE_CONFIGURED))
    else $error("bulk enable disagrees with device status");

  a_stall_no_toggle: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == usbce_pkg::ACT_STALL || action == usbce_pkg::ACT_IGNORE ||
                  action == usbce_pkg::ACT_FORWARD) |-> !data_toggle)
    else $error("data toggle set on a result that arms no ep0 packet");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with no item held back");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && out_load) |=> $stable(state))
    else $error("device state changed without an item advancing");

endmodule

[design/usbce_step.sv]
// Endpoint-zero event decoder: next state and result for one item.
module usbce_step (
  input  usbce_pkg::item_t   item,
  input  usbce_pkg::state_t  cur,
  input  usbce_pkg::cfg_t    cfg,
  output usbce_pkg::state_t  nxt,
  output usbce_pkg::result_t res
);

  logic        setup_ok;
  logic [2:0]  setup_src;
  logic [15:0] setup_len;
  logic [15:0] setup_clamped;
  logic [6:0]  psz;
  logic [15:0] chunk_rem;
  logic [15:0] chunk_off;
  logic [6:0]  chunk_n;
  logic [16:0] out_sum;

  // Standard request decode.
  always_comb begin
    setup_ok  = 1'b0;
    setup_src = usbce_pkg::SRC_ZERO;
    setup_len = '0;
    if ((item.request_type & usbce_pkg::RT_TYPE_MASK) == 8'd0) begin
      case (item.request_code)
        usbce_pkg::REQ_ASSIGN_ADDRESS: begin
          setup_ok = 1'b1;
        end
        usbce_pkg::REQ_GET_DESCRIPTOR: begin
          if (item.request_type == usbce_pkg::RT_STD_DEVICE_IN) begin
            if (item.value_high == usbce_pkg::DESC_DEVICE) begin
              setup_ok  = 1'b1;
              setup_src = usbce_pkg::SRC_DEVICE;
              setup_len = {8'd0, cfg.device_desc_length};
            end else if (item.value_high == usbce_pkg::DESC_CONFIG) begin
              setup_ok  = 1'b1;
              setup_src = usbce_pkg::SRC_CONFIG;
              setup_len = cfg.config_desc_length;
            end else if (item.value_high == usbce_pkg::DESC_STRING &&
                         item.value_low < 8'd4) begin
              setup_ok  = 1'b1;
              setup_src = usbce_pkg::SRC_STRING0 + {1'b0, item.value_low[1:0]};
              case (item.value_low[1:0])
                2'd0:    setup_len = {8'd0, cfg.string0_length};
                2'd1:    setup_len = {8'd0, cfg.string1_length};
                2'd2:    setup_len = {8'd0, cfg.string2_length};
                default: setup_len = {8'd0, cfg.string3_length};
              endcase
            end
          end
        end
        usbce_pkg::REQ_SET_CONFIGURATION: begin
          setup_ok = 1'b1;
        end
        usbce_pkg::REQ_GET_CONFIGURATION: begin
          setup_ok  = 1'b1;
          setup_src = usbce_pkg::SRC_CUR_CFG;
          setup_len = 16'd1;
        end
        usbce_pkg::REQ_GET_INTERFACE: begin
          setup_ok  = 1'b1;
          setup_src = usbce_pkg::SRC_ZERO;
          setup_len = 16'd1;
        end
        default: setup_ok = 1'b0;
      endcase
    end
  end

  // One chunk: at most one packet, taken from what remains.
  always_comb begin
    psz = (cfg.ep0_packet_size > usbce_pkg::MAX_PACKET) ?
          usbce_pkg::MAX_PACKET : cfg.ep0_packet_size;
    setup_clamped = (item.request_length < setup_len) ? item.request_length : setup_len;
    chunk_rem = (item.is_setup && !item.direction_in) ? setup_clamped : cur.bytes_remaining;
    chunk_off = (item.is_setup && !item.direction_in) ? 16'd0 : cur.current_offset;
    chunk_n   = (chunk_rem < {9'd0, psz}) ? chunk_rem[6:0] : psz;
    out_sum   = {1'b0, cur.out_total} + {7'd0, item.out_byte_count};
  end

  always_comb begin
    nxt = cur;
    res = '0;
    res.action = usbce_pkg::ACT_IGNORE;
    case (item.opcode)
      usbce_pkg::OP_BUS_RESET: begin
        nxt.applied_address = '0;
        nxt.pending_address = '0;
        nxt.selected_config = '0;
        nxt.device_phase    = usbce_pkg::PHASE_DEFAULT;
        nxt.in_toggle       = 1'b0;
        nxt.transfer_stage  = usbce_pkg::STAGE_SETUP;
        nxt.out_toggle      = 1'b0;
        res.action          = usbce_pkg::ACT_REARM;
      end
      usbce_pkg::OP_STALL_CLEAR: begin
        nxt.transfer_stage = usbce_pkg::STAGE_SETUP;
        nxt.out_toggle     = 1'b0;
        res.action         = usbce_pkg::ACT_REARM;
      end
      usbce_pkg::OP_TRANSACTION: begin
        if (cur.device_phase != usbce_pkg::PHASE_POWERED) begin
          if (item.endpoint == 4'd1) begin
            if (!item.direction_in) begin
              res.action = usbce_pkg::ACT_FORWARD;
            end
          end else if (item.endpoint == 4'd0) begin
            if (!item.direction_in && item.is_setup) begin
              nxt.transfer_stage  = usbce_pkg::STAGE_SETUP;
              nxt.current_offset  = '0;
              nxt.bytes_remaining = setup_len;
              nxt.current_source  = setup_src;
              if (!setup_ok) begin
                res.action = usbce_pkg::ACT_STALL;
              end else begin
                if (item.request_code == usbce_pkg::REQ_ASSIGN_ADDRESS) begin
                  nxt.device_phase    = usbce_pkg::PHASE_ADDRESSED;
                  nxt.pending_address = item.value_low[6:0];
                end else if (item.request_code == usbce_pkg::REQ_SET_CONFIGURATION) begin
                  nxt.selected_config = item.value_low;
                  nxt.device_phase    = (item.value_low == 8'd0) ?
                                        usbce_pkg::PHASE_ADDRESSED :
                                        usbce_pkg::PHASE_CONFIGURED;
                end
                if (item.request_type[7]) begin
                  res.action          = usbce_pkg::ACT_SEND_IN;
                  res.data_source     = setup_src;
                  res.source_offset   = '0;
                  res.chunk_length    = chunk_n;
                  res.data_toggle     = 1'b1;
                  nxt.bytes_remaining = setup_clamped - {9'd0, chunk_n};
                  nxt.current_offset  = {9'd0, chunk_n};
                  nxt.transfer_stage  = usbce_pkg::STAGE_IN;
                  nxt.in_toggle       = 1'b1;
                end else begin
                  nxt.transfer_stage = usbce_pkg::STAGE_OUT;
                  nxt.out_toggle     = 1'b1;
                  nxt.out_total      = '0;
                  res.action         = usbce_pkg::ACT_ZLP_IN;
                  res.data_toggle    = 1'b1;
                end
              end
            end else if (!item.direction_in) begin
              if (cur.transfer_stage == usbce_pkg::STAGE_OUT) begin
                nxt.out_total   = out_sum[16] ? 16'hFFFF : out_sum[15:0];
                nxt.out_toggle  = ~cur.out_toggle;
                res.action      = usbce_pkg::ACT_OUT_OK;
                res.data_toggle = ~cur.out_toggle;
              end else begin
                nxt.transfer_stage = usbce_pkg::STAGE_SETUP;
                nxt.out_toggle     = 1'b0;
                res.action         = usbce_pkg::ACT_REARM;
              end
            end else begin
              // The status IN of an address request makes the new address take effect.
              if (cur.applied_address == 7'd0 &&
                  cur.device_phase == usbce_pkg::PHASE_ADDRESSED) begin
                nxt.applied_address = cur.pending_address;
                if (cur.pending_address == 7'd0) begin
                  nxt.device_phase = usbce_pkg::PHASE_DEFAULT;
                end
              end
              if (cur.transfer_stage == usbce_pkg::STAGE_IN) begin
                res.action          = usbce_pkg::ACT_SEND_IN;
                res.data_source     = cur.current_source;
                res.source_offset   = cur.current_offset;
                res.chunk_length    = chunk_n;
                res.data_toggle     = ~cur.in_toggle;
                nxt.bytes_remaining = chunk_rem - {9'd0, chunk_n};
                nxt.current_offset  = chunk_off + {9'd0, chunk_n};
                nxt.in_toggle       = ~cur.in_toggle;
              end else begin
                nxt.transfer_stage = usbce_pkg::STAGE_SETUP;
                nxt.out_toggle     = 1'b0;
                res.action         = usbce_pkg::ACT_REARM;
              end
            end
          end
        end
      end
      default: res.action = usbce_pkg::ACT_IGNORE;
    endcase
    res.device_status        = nxt.device_phase;
    res.bus_address          = nxt.applied_address;
    res.active_configuration = nxt.selected_config;
    res.bulk_enabled         = (nxt.device_phase == usbce_pkg::PHASE_CONFIGURED);
  end

endmodule
